>>> hw/rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared constants and controller-to-datapath command type for the
// demand-paging translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

   localparam int VA_WIDTH     = 16;
   localparam int PA_WIDTH     = 15;
   localparam int OFFSET_WIDTH = 8;
   localparam int PAGE_WIDTH   = VA_WIDTH - OFFSET_WIDTH;
   localparam int PAGE_ENTRIES = 2 ** PAGE_WIDTH;
   localparam int FETCH_WIDTH  = 8;
   localparam int COUNT_WIDTH  = 32;

   localparam int DEF_TLB_ENTRIES = 16;
   localparam int DEF_FRAME_COUNT = 128;

   typedef struct packed {
      logic load;
      logic lookup;
      logic resolve;
   } cmd_type;

endpackage

>>> hw/rtl/tlb_page_table_translator_top.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator_top
// Demand-paging address translator: TLB, page map, FIFO frame replacement.
//
//   channel  ports                    handshake
//   req      req_virtual_address      taken when start is high, busy low
//   rsp      rsp_* (six fields)       rsp_valid high one cycle, no stall
//
// An item passes capture, lookup (TLB compare and page map / owner memory
// reads) and resolve (hit, map or fault update) before the next start can
// be taken. The result strobe is high in the cycle after resolve,
// when the next item may already be taken. Reset clears TLB valid bits,
// page resident bits, pointers and counters at once; no clearing pass.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_top
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
   parameter int FRAME_COUNT = DEF_FRAME_COUNT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VA_WIDTH-1:0]    req_virtual_address,
   output logic                   rsp_valid,
   output logic [PA_WIDTH-1:0]    rsp_physical_address,
   output logic                   rsp_tlb_hit,
   output logic                   rsp_page_fault,
   output logic [FETCH_WIDTH-1:0] rsp_fetch_page,
   output logic [COUNT_WIDTH-1:0] rsp_hit_total,
   output logic [COUNT_WIDTH-1:0] rsp_fault_total
);

   cmd_type cmd;

   tlbpt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   tlbpt_datapath #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .FRAME_COUNT (FRAME_COUNT)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_fetch_page       (rsp_fetch_page),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_fault_total      (rsp_fault_total)
   );

endmodule

>>> hw/rtl/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer: take an item, look it up, then resolve (hit, map or fault).
// ----------------------------------------------------------------------------
module tlbpt_ctrl
   import tlbpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_LOOKUP  = 3'b010,
      ST_RESOLVE = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP:  state_in = ST_RESOLVE;
         ST_RESOLVE: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.load    = (state_ff == ST_IDLE) && start;
   assign cmd.lookup  = (state_ff == ST_LOOKUP);
   assign cmd.resolve = (state_ff == ST_RESOLVE);

endmodule

>>> hw/rtl/tlbpt_datapath.sv
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB, page map, frame owner map, FIFO pointers, counters and result
// registers.
// ----------------------------------------------------------------------------
module tlbpt_datapath
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
   parameter int FRAME_COUNT = DEF_FRAME_COUNT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [VA_WIDTH-1:0]    req_virtual_address,
   output logic                   rsp_valid,
   output logic [PA_WIDTH-1:0]    rsp_physical_address,
   output logic                   rsp_tlb_hit,
   output logic                   rsp_page_fault,
   output logic [FETCH_WIDTH-1:0] rsp_fetch_page,
   output logic [COUNT_WIDTH-1:0] rsp_hit_total,
   output logic [COUNT_WIDTH-1:0] rsp_fault_total
);

   localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
   localparam int FRAME_W   = $clog2(FRAME_COUNT);

   // item
   logic [VA_WIDTH-1:0]     va_ff;
   logic [PAGE_WIDTH-1:0]   page;
   logic [OFFSET_WIDTH-1:0] offset;

   // TLB
   logic [PAGE_WIDTH-1:0]   tlb_tag_ff   [TLB_ENTRIES];
   logic [PAGE_WIDTH-1:0]   tlb_tag_in   [TLB_ENTRIES];
   logic [FRAME_W-1:0]      tlb_frame_ff [TLB_ENTRIES];
   logic [FRAME_W-1:0]      tlb_frame_in [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0]  tlb_valid_ff;
   logic [TLB_ENTRIES-1:0]  tlb_valid_in;
   logic [TLB_IDX_W-1:0]    tlb_fill_ff;
   logic [TLB_IDX_W-1:0]    tlb_fill_in;

   // page map: resident bits in flops, frame numbers in memory
   logic [PAGE_ENTRIES-1:0] page_valid_ff;
   logic [PAGE_ENTRIES-1:0] page_valid_in;
   logic [FRAME_W-1:0]      page_frame_mem  [PAGE_ENTRIES];
   logic [PAGE_WIDTH-1:0]   frame_owner_mem [FRAME_COUNT];

   logic [FRAME_W-1:0]      frame_ptr_ff;
   logic [FRAME_W-1:0]      frame_ptr_in;
   logic                    wrapped_ff;
   logic                    wrapped_in;

   // lookup results
   logic                    tlb_match;
   logic [FRAME_W-1:0]      tlb_match_frame;
   logic                    hit_ff;
   logic [FRAME_W-1:0]      hit_frame_ff;
   logic                    resident_ff;
   logic [FRAME_W-1:0]      map_frame_ff;
   logic [PAGE_WIDTH-1:0]   owner_ff;

   // resolve
   logic                         fault;
   logic [FRAME_W-1:0]           frame;
   logic [FRAME_W+OFFSET_WIDTH-1:0] pa_full;

   logic [COUNT_WIDTH-1:0]  hit_cnt_ff;
   logic [COUNT_WIDTH-1:0]  hit_cnt_in;
   logic [COUNT_WIDTH-1:0]  fault_cnt_ff;
   logic [COUNT_WIDTH-1:0]  fault_cnt_in;

   logic                    rsp_valid_ff;
   logic [PA_WIDTH-1:0]     rsp_pa_ff;
   logic                    rsp_hit_ff;
   logic                    rsp_fault_ff;
   logic [FETCH_WIDTH-1:0]  rsp_fetch_ff;

   assign page   = va_ff[VA_WIDTH-1:OFFSET_WIDTH];
   assign offset = va_ff[OFFSET_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) va_ff <= req_virtual_address;
   end

   // lowest matching valid entry wins
   always_comb begin
      tlb_match       = 1'b0;
      tlb_match_frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && (tlb_tag_ff[i] == page)) begin
            tlb_match       = 1'b1;
            tlb_match_frame = tlb_frame_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff       <= tlb_match;
         hit_frame_ff <= tlb_match_frame;
         resident_ff  <= page_valid_ff[page];
         map_frame_ff <= page_frame_mem[page];
         owner_ff     <= frame_owner_mem[frame_ptr_ff];
      end
   end

   assign fault   = !hit_ff && !resident_ff;
   assign frame   = hit_ff ? hit_frame_ff : (resident_ff ? map_frame_ff : frame_ptr_ff);
   assign pa_full = {frame, offset};

   // TLB and FIFO pointer updates on a fault
   always_comb begin
      tlb_tag_in   = tlb_tag_ff;
      tlb_frame_in = tlb_frame_ff;
      tlb_valid_in = tlb_valid_ff;
      tlb_fill_in  = tlb_fill_ff;
      frame_ptr_in = frame_ptr_ff;
      wrapped_in   = wrapped_ff;
      if (cmd.resolve && fault) begin
         if (!wrapped_ff) begin
            tlb_tag_in[tlb_fill_ff]   = page;
            tlb_frame_in[tlb_fill_ff] = frame_ptr_ff;
            tlb_valid_in[tlb_fill_ff] = 1'b1;
            tlb_fill_in = (tlb_fill_ff == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
                          '0 : tlb_fill_ff + 1'b1;
         end else begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
               if (tlb_valid_ff[i] && (tlb_frame_ff[i] == frame_ptr_ff)) begin
                  tlb_tag_in[i] = page;
               end
            end
         end
         if (frame_ptr_ff == FRAME_W'(FRAME_COUNT - 1)) begin
            frame_ptr_in = '0;
            wrapped_in   = 1'b1;
         end else begin
            frame_ptr_in = frame_ptr_ff + 1'b1;
         end
      end
   end

   // evict old owner first; the new mapping takes precedence
   always_comb begin
      page_valid_in = page_valid_ff;
      if (cmd.resolve && fault) begin
         if (wrapped_ff) page_valid_in[owner_ff] = 1'b0;
         page_valid_in[page] = 1'b1;
      end
   end

   always_comb begin
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      if (cmd.resolve && hit_ff && (hit_cnt_ff != '1)) begin
         hit_cnt_in = hit_cnt_ff + 1'b1;
      end
      if (cmd.resolve && fault && (fault_cnt_ff != '1)) begin
         fault_cnt_in = fault_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      tlb_tag_ff   <= tlb_tag_in;
      tlb_frame_ff <= tlb_frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff  <= '0;
         tlb_fill_ff   <= '0;
         frame_ptr_ff  <= '0;
         wrapped_ff    <= 1'b0;
         hit_cnt_ff    <= '0;
         fault_cnt_ff  <= '0;
         page_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tlb_valid_ff  <= tlb_valid_in;
         tlb_fill_ff   <= tlb_fill_in;
         frame_ptr_ff  <= frame_ptr_in;
         wrapped_ff    <= wrapped_in;
         hit_cnt_ff    <= hit_cnt_in;
         fault_cnt_ff  <= fault_cnt_in;
         page_valid_ff <= page_valid_in;
         rsp_valid_ff  <= cmd.resolve;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve && fault) begin
         page_frame_mem[page]          <= frame_ptr_ff;
         frame_owner_mem[frame_ptr_ff] <= page;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         rsp_pa_ff    <= PA_WIDTH'(pa_full);
         rsp_hit_ff   <= hit_ff;
         rsp_fault_ff <= fault;
         rsp_fetch_ff <= fault ? FETCH_WIDTH'(page) : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_fetch_page       = rsp_fetch_ff;
   assign rsp_hit_total        = hit_cnt_ff;
   assign rsp_fault_total      = fault_cnt_ff;

endmodule

>>> test/tlb_translation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlb_translation_checker
// Watches the request and response channels of the demand-paging translator.
// Keeps its own copy of the TLB, page map, frame owners and counters, works
// out the translation for every accepted request, and compares each response
// field by field with the oldest outstanding translation.
// ----------------------------------------------------------------------------
module tlb_translation_checker
   import tlbpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [VA_WIDTH-1:0]    req_virtual_address,
   input  logic                   rsp_valid,
   input  logic [PA_WIDTH-1:0]    rsp_physical_address,
   input  logic                   rsp_tlb_hit,
   input  logic                   rsp_page_fault,
   input  logic [FETCH_WIDTH-1:0] rsp_fetch_page,
   input  logic [COUNT_WIDTH-1:0] rsp_hit_total,
   input  logic [COUNT_WIDTH-1:0] rsp_fault_total,
   output int                     failures,
   output int                     outstanding,
   output int                     checked,
   output int                     tlb_hits_seen,
   output int                     faults_seen,
   output logic                   pool_wrapped
);

   localparam int FRAME_WIDTH = $clog2(DEF_FRAME_COUNT);
   localparam int SLOT_WIDTH  = $clog2(DEF_TLB_ENTRIES);

   typedef struct packed {
      logic [PA_WIDTH-1:0]    physical_address;
      logic                   tlb_hit;
      logic                   page_fault;
      logic [FETCH_WIDTH-1:0] fetch_page;
      logic [COUNT_WIDTH-1:0] hit_total;
      logic [COUNT_WIDTH-1:0] fault_total;
   } translation_type;

   logic [PAGE_WIDTH-1:0]  tlb_tag   [DEF_TLB_ENTRIES];
   logic                   tlb_valid [DEF_TLB_ENTRIES];
   logic [FRAME_WIDTH-1:0] tlb_frame [DEF_TLB_ENTRIES];
   logic [SLOT_WIDTH-1:0]  tlb_fill;
   // 0: not resident, otherwise frame + 1
   logic [FRAME_WIDTH:0]   page_map    [PAGE_ENTRIES];
   logic [PAGE_WIDTH-1:0]  frame_owner [DEF_FRAME_COUNT];
   logic [FRAME_WIDTH-1:0] next_frame;
   logic                   wrapped;
   logic [COUNT_WIDTH-1:0] hit_count;
   logic [COUNT_WIDTH-1:0] fault_count;

   translation_type pending_translations[$];

   function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic translation_type translate_address(input logic [VA_WIDTH-1:0] va);
      translation_type        t;
      logic [PAGE_WIDTH-1:0]  page;
      logic [FRAME_WIDTH-1:0] frame;
      logic [PAGE_WIDTH-1:0]  old_page;
      logic                   found;
      page  = va[VA_WIDTH-1:OFFSET_WIDTH];
      found = 1'b0;
      frame = '0;
      t     = '0;
      for (int i = 0; i < DEF_TLB_ENTRIES; i++) begin
         if (!found && tlb_valid[i] && tlb_tag[i] == page) begin
            found = 1'b1;
            frame = tlb_frame[i];
         end
      end
      if (found) begin
         t.tlb_hit = 1'b1;
         hit_count = bump(hit_count);
      end else if (page_map[page] != '0) begin
         frame = FRAME_WIDTH'(page_map[page] - 1'b1);
      end else begin
         t.page_fault = 1'b1;
         t.fetch_page = page;
         fault_count  = bump(fault_count);
         frame        = next_frame;
         if (!wrapped) begin
            tlb_tag[tlb_fill]   = page;
            tlb_frame[tlb_fill] = frame;
            tlb_valid[tlb_fill] = 1'b1;
            tlb_fill            = tlb_fill + 1'b1;
         end else begin
            old_page           = frame_owner[frame];
            page_map[old_page] = '0;
            for (int i = 0; i < DEF_TLB_ENTRIES; i++)
               if (tlb_valid[i] && tlb_frame[i] == frame)
                  tlb_tag[i] = page;
         end
         page_map[page]     = {1'b0, frame} + 1'b1;
         frame_owner[frame] = page;
         next_frame         = next_frame + 1'b1;
         if (next_frame == '0)
            wrapped = 1'b1;
      end
      t.physical_address = {frame, va[OFFSET_WIDTH-1:0]};
      t.hit_total        = hit_count;
      t.fault_total      = fault_count;
      return t;
   endfunction

   always @(posedge clock) begin
      translation_type want;
      if (reset) begin
         for (int i = 0; i < DEF_TLB_ENTRIES; i++) begin
            tlb_tag[i]   = '0;
            tlb_valid[i] = 1'b0;
            tlb_frame[i] = '0;
         end
         for (int p = 0; p < PAGE_ENTRIES; p++)
            page_map[p] = '0;
         for (int f = 0; f < DEF_FRAME_COUNT; f++)
            frame_owner[f] = '0;
         tlb_fill    = '0;
         next_frame  = '0;
         wrapped     = 1'b0;
         hit_count   = '0;
         fault_count = '0;
         pending_translations.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_translations.size() == 0) begin
               $error("response with no translation outstanding");
               failures++;
            end else begin
               want = pending_translations.pop_front();
               checked++;
               if (rsp_tlb_hit)
                  tlb_hits_seen++;
               if (rsp_page_fault)
                  faults_seen++;
               if (rsp_physical_address !== want.physical_address) begin
                  $error("physical_address: expected %h, got %h",
                         want.physical_address, rsp_physical_address);
                  failures++;
               end
               if (rsp_tlb_hit !== want.tlb_hit) begin
                  $error("tlb_hit: expected %b, got %b", want.tlb_hit, rsp_tlb_hit);
                  failures++;
               end
               if (rsp_page_fault !== want.page_fault) begin
                  $error("page_fault: expected %b, got %b",
                         want.page_fault, rsp_page_fault);
                  failures++;
               end
               if (rsp_fetch_page !== want.fetch_page) begin
                  $error("fetch_page: expected %h, got %h",
                         want.fetch_page, rsp_fetch_page);
                  failures++;
               end
               if (rsp_hit_total !== want.hit_total) begin
                  $error("hit_total: expected %0d, got %0d",
                         want.hit_total, rsp_hit_total);
                  failures++;
               end
               if (rsp_fault_total !== want.fault_total) begin
                  $error("fault_total: expected %0d, got %0d",
                         want.fault_total, rsp_fault_total);
                  failures++;
               end
            end
         end
         if (start && !busy)
            pending_translations.push_back(translate_address(req_virtual_address));
      end
      outstanding  = pending_translations.size();
      pool_wrapped = wrapped;
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives virtual addresses into the translator: a directed run through TLB
// hits, page map hits and faults, then random addresses biased towards a
// recent working set so the frame pool wraps and evictions and TLB retags
// occur. Request gaps vary by phase; the checker predicts every response.
// ----------------------------------------------------------------------------
module testbench;
   import tlbpt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 310;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [VA_WIDTH-1:0]    req_virtual_address;
   logic                   rsp_valid;
   logic [PA_WIDTH-1:0]    rsp_physical_address;
   logic                   rsp_tlb_hit;
   logic                   rsp_page_fault;
   logic [FETCH_WIDTH-1:0] rsp_fetch_page;
   logic [COUNT_WIDTH-1:0] rsp_hit_total;
   logic [COUNT_WIDTH-1:0] rsp_fault_total;

   int   failures;
   int   outstanding;
   int   checked;
   int   tlb_hits_seen;
   int   faults_seen;
   logic pool_wrapped;
   int   cycles;

   logic [PAGE_WIDTH-1:0] recent_pages[32];
   int                    recent_head;

   tlb_page_table_translator_top u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_fetch_page       (rsp_fetch_page),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_fault_total      (rsp_fault_total)
   );

   tlb_translation_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_fetch_page       (rsp_fetch_page),
      .rsp_hit_total        (rsp_hit_total),
      .rsp_fault_total      (rsp_fault_total),
      .failures             (failures),
      .outstanding          (outstanding),
      .checked              (checked),
      .tlb_hits_seen        (tlb_hits_seen),
      .faults_seen          (faults_seen),
      .pool_wrapped         (pool_wrapped)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tlb_page_table_translator_top: mismatch");
         $finish;
      end
   end

   task automatic issue_translation(input logic [VA_WIDTH-1:0] va, input int idle_pct);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start               <= 1'b1;
      req_virtual_address <= va;
      recent_pages[recent_head] = va[VA_WIDTH-1:OFFSET_WIDTH];
      recent_head = (recent_head + 1) % 32;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic drain_translations();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // half the time a recently used page, so TLB and page map hits mix with faults
   function automatic logic [VA_WIDTH-1:0] pick_address();
      int                    roll;
      logic [PAGE_WIDTH-1:0] page;
      roll = $urandom_range(99);
      if (roll < 50)
         page = recent_pages[$urandom_range(31)];
      else if (roll < 85)
         page = PAGE_WIDTH'($urandom_range(PAGE_ENTRIES - 1));
      else
         return VA_WIDTH'($urandom);
      return {page, OFFSET_WIDTH'($urandom)};
   endfunction

   initial begin
      int idle_by_phase[4];
      idle_by_phase = '{0, 63, 0, 8};
      reset               <= 1'b1;
      start               <= 1'b0;
      req_virtual_address <= '0;
      recent_head = 0;
      for (int i = 0; i < 32; i++)
         recent_pages[i] = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // first and last page, offset extremes, TLB hits
      issue_translation(16'h0000, 0);
      issue_translation(16'h00FF, 0);
      issue_translation(16'hFFFF, 0);
      issue_translation(16'hFF00, 0);
      // fill the TLB round so page 0 leaves it
      for (int p = 1; p < 16; p++)
         issue_translation({8'(p), 8'(p * 17)}, 0);
      // page map hit after TLB eviction, then a TLB hit
      issue_translation(16'h0012, 0);
      issue_translation(16'hFF80, 0);
      drain_translations();

      for (int phase = 0; phase < 4; phase++) begin
         for (int n = 0; n < PHASE_ITEMS; n++)
            issue_translation(pick_address(), idle_by_phase[phase]);
         drain_translations();
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      $display("%0d translations checked: %0d TLB hits, %0d page faults", checked,
               tlb_hits_seen, faults_seen);
      $display("frame pool wrapped with evictions: %0d", pool_wrapped);
      if (failures == 0)
         $display("tlb_page_table_translator_top: match");
      else
         $display("tlb_page_table_translator_top: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/tlbpt_pkg.sv
hw/rtl/tlbpt_ctrl.sv
hw/rtl/tlbpt_datapath.sv
hw/rtl/tlb_page_table_translator_top.sv
test/tlb_translation_checker.sv
test/testbench.sv
